// ----- hdl/text_console_character_writer_core_assert.svh -----
// assertion macros for the text console writer core
// expects clk and arst_n in the scope of use
`ifndef TEXT_CONSOLE_CHARACTER_WRITER_CORE_ASSERT_SVH
`define TEXT_CONSOLE_CHARACTER_WRITER_CORE_ASSERT_SVH

// same-cycle implication
`define TCW_ASSERT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tcw assertion failed");

// next-cycle implication
`define TCW_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tcw assertion failed");

`endif

// ----- hdl/tcw_pkg.sv -----
// shared types and constants for the text console writer core
// no dependencies
package tcw_pkg;

	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_BACKSPACE = 8'h08;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_ERROR     = 8'h45;

	localparam logic [1:0] KIND_PUT   = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	localparam logic REG_NORMAL_COLOR = 1'b0;
	localparam logic REG_ERROR_COLOR  = 1'b1;

	localparam logic [7:0] NORMAL_COLOR_RESET = 8'd15;
	localparam logic [7:0] ERROR_COLOR_RESET  = 8'd79;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] character;
		logic [7:0] attribute;
		logic       at_cursor;
		logic [7:0] column;
		logic [7:0] line;
	} in_item_t;

	typedef struct packed {
		logic [6:0] cursor_column;
		logic [4:0] cursor_line;
		logic [7:0] cell_character;
		logic [7:0] cell_attribute;
		logic       position_error;
		logic       scrolled;
	} out_item_t;

	// where a sweep starts; every sweep ends at the last cell
	typedef enum logic [1:0] {
		SW_ALL     = 2'd0,
		SW_SCROLL  = 2'd1,
		SW_LASTROW = 2'd2
	} sweep_kind_t;

	typedef struct packed {
		logic        start;
		sweep_kind_t kind;
	} sweep_req_t;

	typedef struct packed {
		logic active;
		logic last;
	} sweep_stat_t;

endpackage

// ----- hdl/tcw_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/tcw_sweep.sv -----
// shared cell address counter for reset clear, clear, scroll and row fill
// depends on tcw_pkg
module tcw_sweep import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int CELLS = 2000,
	localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  sweep_req_t    req,
	output logic [AW-1:0] addr,
	output sweep_stat_t   stat
);

	localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
	localparam logic [AW-1:0] ROW_STEP   = AW'(COLUMNS);
	localparam logic [AW-1:0] FILL_START = AW'(CELLS - COLUMNS);

	logic          active_q;
	logic [AW-1:0] cnt_q;

	// comes out of reset already sweeping the whole store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b1;
			cnt_q    <= '0;
		end else if (req.start) begin
			active_q <= 1'b1;
			case (req.kind)
				SW_ALL:     cnt_q <= '0;
				SW_SCROLL:  cnt_q <= ROW_STEP;
				SW_LASTROW: cnt_q <= FILL_START;
				default:    cnt_q <= '0;
			endcase
		end else if (active_q) begin
			if (cnt_q == LAST_CELL) begin
				active_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign addr        = cnt_q;
	assign stat.active = active_q;
	assign stat.last   = active_q && (cnt_q == LAST_CELL);

endmodule

// ----- hdl/text_console_character_writer_core.sv -----
// text console writer core: cursor, cell store and a sweep sequencer
// a put goes through exec to done, a valid read also waits for the ram read;
// a new request is taken only in idle, once the result of the last one is loaded
// scroll moves rows up and zeroes the last row; clear writes every cell;
// both on one write port; the store is zeroed after reset before requests are taken
// depends on tcw_pkg, tcw_ram, tcw_sweep and the assertion macro header
module text_console_character_writer_core import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item,
	input  logic      cfg_en,
	input  logic      cfg_index,
	input  logic [7:0] cfg_data
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int RW = $clog2(ROWS);
	localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
	localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);
	localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
	localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);

	typedef enum logic [8:0] {
		S_INIT   = 9'b000000001,
		S_IDLE   = 9'b000000010,
		S_EXEC   = 9'b000000100,
		S_RDWAIT = 9'b000001000,
		S_SCROLL = 9'b000010000,
		S_DRAIN  = 9'b000100000,
		S_FILL   = 9'b001000000,
		S_CLEAR  = 9'b010000000,
		S_DONE   = 9'b100000000
	} state_t;

	state_t      state_q;
	logic [7:0]  normal_color_q;
	logic [7:0]  error_color_q;
	logic [CW-1:0] cur_col_q;
	logic [RW-1:0] cur_row_q;
	in_item_t    item_q;
	logic [CW-1:0] tcol_q;
	logic [RW-1:0] trow_q;
	logic [AW-1:0] pos_q;
	logic        err_q;
	logic        scr_q;
	logic [15:0] cell_q;
	logic        out_valid_q;
	out_item_t   out_q;
	logic        scr_pend_s1;
	logic [AW-1:0] scr_addr_s1;

	// ram and sweep hookup
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [15:0]   ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [15:0]   ram_rdata;
	sweep_req_t    sw_req;
	logic [AW-1:0] sw_addr;
	sweep_stat_t   sw_stat;

	tcw_ram #(
		.WIDTH(16),
		.DEPTH(CELLS)
	) u_cells (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	tcw_sweep #(
		.COLUMNS(COLUMNS),
		.CELLS(CELLS)
	) u_sweep (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (sw_req),
		.addr  (sw_addr),
		.stat  (sw_stat)
	);

	// target selection at accept
	logic          use_cur;
	logic          bad_pos;
	logic [CW-1:0] sel_col;
	logic [RW-1:0] sel_row;
	logic [16:0]   sel_pos;

	always_comb begin
		use_cur = in_item.at_cursor ||
			((in_item.kind != KIND_PUT) && (in_item.kind != KIND_READ));
		bad_pos = !use_cur && ((9'(in_item.column) >= 9'(COLUMNS)) ||
			(9'(in_item.line) >= 9'(ROWS)));
		sel_col = use_cur ? cur_col_q : in_item.column[CW-1:0];
		sel_row = use_cur ? cur_row_q : in_item.line[RW-1:0];
		sel_pos = 17'(sel_row) * 17'(COLUMNS) + 17'(sel_col);
	end

	// cursor step for a put
	logic          is_nl;
	logic          is_bs;
	logic [7:0]    attr_eff;
	logic [CW-1:0] nxt_col;
	logic [RW-1:0] nxt_row;
	logic          need_scroll;

	always_comb begin
		is_nl       = item_q.character == CH_NEWLINE;
		is_bs       = item_q.character == CH_BACKSPACE;
		attr_eff    = (item_q.attribute == 8'd0) ? normal_color_q : item_q.attribute;
		nxt_col     = tcol_q;
		nxt_row     = trow_q;
		need_scroll = 1'b0;
		if (is_nl || (!is_bs && (tcol_q == LAST_COL))) begin
			nxt_col = '0;
			if (trow_q == LAST_ROW) begin
				need_scroll = 1'b1;
			end else begin
				nxt_row = trow_q + 1'b1;
			end
		end else if (!is_bs) begin
			nxt_col = tcol_q + 1'b1;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = sw_addr;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = sw_addr;
		sw_req.start = 1'b0;
		sw_req.kind  = SW_ALL;
		case (state_q)
			S_INIT: begin
				ram_we = 1'b1;
			end
			S_EXEC: begin
				if (item_q.kind == KIND_PUT) begin
					if (err_q) begin
						ram_we    = 1'b1;
						ram_waddr = LAST_CELL;
						ram_wdata = {error_color_q, CH_ERROR};
					end else begin
						ram_we    = !is_nl;
						ram_waddr = pos_q;
						ram_wdata = {attr_eff, is_bs ? CH_SPACE : item_q.character};
						sw_req.start = need_scroll;
						sw_req.kind  = SW_SCROLL;
					end
				end else if (item_q.kind == KIND_READ) begin
					ram_re    = !err_q;
					ram_raddr = pos_q;
				end else if (item_q.kind == KIND_CLEAR) begin
					sw_req.start = 1'b1;
				end
			end
			S_SCROLL: begin
				// read one row down, write the cell read last cycle one row up
				ram_re    = 1'b1;
				ram_we    = scr_pend_s1;
				ram_waddr = scr_addr_s1;
				ram_wdata = ram_rdata;
			end
			S_DRAIN: begin
				ram_we    = scr_pend_s1;
				ram_waddr = scr_addr_s1;
				ram_wdata = ram_rdata;
				sw_req.start = 1'b1;
				sw_req.kind  = SW_LASTROW;
			end
			S_FILL: begin
				ram_we = 1'b1;
			end
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_wdata = {normal_color_q, CH_SPACE};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_color_q <= NORMAL_COLOR_RESET;
			error_color_q  <= ERROR_COLOR_RESET;
		end else if (cfg_en) begin
			case (cfg_index)
				REG_NORMAL_COLOR: normal_color_q <= cfg_data;
				REG_ERROR_COLOR:  error_color_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_pend_s1 <= 1'b0;
		end else begin
			scr_pend_s1 <= state_q == S_SCROLL;
		end
	end

	always_ff @(posedge clk) begin
		scr_addr_s1 <= sw_addr - ROW_STEP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_INIT;
			cur_col_q <= '0;
			cur_row_q <= '0;
		end else begin
			case (state_q)
				S_INIT: begin
					if (sw_stat.last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (item_q.kind)
						KIND_PUT: begin
							if (err_q) begin
								state_q <= S_DONE;
							end else begin
								cur_col_q <= nxt_col;
								cur_row_q <= nxt_row;
								state_q   <= need_scroll ? S_SCROLL : S_DONE;
							end
						end
						KIND_READ: state_q <= err_q ? S_DONE : S_RDWAIT;
						KIND_CLEAR: begin
							cur_col_q <= '0;
							cur_row_q <= '0;
							state_q   <= S_CLEAR;
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_RDWAIT: state_q <= S_DONE;
				S_SCROLL: begin
					if (sw_stat.last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: state_q <= S_FILL;
				S_FILL, S_CLEAR: begin
					if (sw_stat.last) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request payload and per-item results
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			item_q <= in_item;
			tcol_q <= sel_col;
			trow_q <= sel_row;
			pos_q  <= sel_pos[AW-1:0];
			err_q  <= bad_pos;
			scr_q  <= 1'b0;
			cell_q <= '0;
		end else begin
			if (state_q == S_EXEC && item_q.kind == KIND_PUT && !err_q) begin
				scr_q <= need_scroll;
			end
			if (state_q == S_RDWAIT) begin
				cell_q <= ram_rdata;
			end
		end
	end

	logic out_load;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.cursor_column  <= 7'(cur_col_q);
			out_q.cursor_line    <= 5'(cur_row_q);
			out_q.cell_character <= cell_q[7:0];
			out_q.cell_attribute <= cell_q[15:8];
			out_q.position_error <= err_q;
			out_q.scrolled       <= scr_q;
		end
	end

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	`include "text_console_character_writer_core_assert.svh"

	`TCW_ASSERT(a_sweep_busy, (state_q == S_INIT || state_q == S_SCROLL || state_q == S_FILL || state_q == S_CLEAR), sw_stat.active)
	`TCW_ASSERT_NEXT(a_drain_fill, state_q == S_DRAIN, state_q == S_FILL && sw_stat.active)
	`TCW_ASSERT(a_scroll_home, out_valid && out_item.scrolled, out_item.cursor_column == 7'd0 && out_item.cursor_line == 5'(ROWS - 1))
	`TCW_ASSERT(a_error_quiet, out_valid && out_item.position_error, out_item.cell_character == 8'd0 && out_item.cell_attribute == 8'd0 && !out_item.scrolled)

endmodule
